// File: design/gbra_pkg.sv
// Package for the grid box region allocator.
// Holds the beat payload types, table entry type, codes and helper functions.
// No dependencies.
package gbra_pkg;

  localparam int CoordBits   = 10;
  localparam int SizeBits    = CoordBits + 1;
  localparam int GridRegBits = 11;
  localparam int OwnerBits   = 8;
  localparam int CfgIdxBits  = 2;
  localparam int DefMaxBoxes = 16;

  localparam logic [SizeBits-1:0] GridCap = SizeBits'(1) << CoordBits;

  typedef enum logic [1:0] {
    ModeAlloc   = 2'd0,
    ModeFirstFit = 2'd1,
    ModeRelease = 2'd2,
    ModeQuery   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBounds   = 3'd1,
    StOverlap  = 3'd2,
    StNoFree   = 3'd3,
    StNotFound = 3'd4,
    StFull     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgGridX = 2'd0,
    CfgGridY = 2'd1,
    CfgGridZ = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
    logic [CoordBits-1:0] pos_z;
    logic [SizeBits-1:0]  extent_x;
    logic [SizeBits-1:0]  extent_y;
    logic [SizeBits-1:0]  extent_z;
    logic [OwnerBits-1:0] owner_id;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [CoordBits-1:0] box_x;
    logic [CoordBits-1:0] box_y;
    logic [CoordBits-1:0] box_z;
    logic [SizeBits-1:0]  box_size_x;
    logic [SizeBits-1:0]  box_size_y;
    logic [SizeBits-1:0]  box_size_z;
    logic [OwnerBits-1:0] box_owner;
  } out_t;

  typedef struct packed {
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] cz;
    logic [SizeBits-1:0]  sx;
    logic [SizeBits-1:0]  sy;
    logic [SizeBits-1:0]  sz;
    logic [OwnerBits-1:0] owner;
  } entry_t;

  // Results of comparing one stored box against the current request.
  typedef struct packed {
    logic                hit;
    logic                contains;
    logic                match;
    logic [SizeBits-1:0] end_x;
    logic [SizeBits-1:0] end_y;
    logic [SizeBits-1:0] end_z;
  } geom_t;

  function automatic logic [SizeBits-1:0] eff_grid(input logic [GridRegBits-1:0] g);
    logic [SizeBits-1:0] r;
    if (g > GridRegBits'(GridCap)) begin
      r = GridCap;
    end else begin
      r = SizeBits'(g);
    end
    return r;
  endfunction

  function automatic out_t err_out(input status_e st);
    out_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

endpackage

// File: design/grid_box_region_allocator_core.sv
// Grid box region allocator: an ordered table of 3D boxes inside a configured grid.
// Depends on gbra_pkg, gbra_table and gbra_geom.
//
// Each request beat gives one result beat. The table sits in a memory with
// registered read data, and every pass over the table reads each stored box and
// then compares it. Release also moves each later entry down one slot to close
// the gap. First-fit tests candidate corners in z, y, x order: each tested corner
// costs one pass over the table and each step to the next candidate another pass.
// A new request is taken while the previous result still waits in the output
// register. Grid registers reset to 1024.
module grid_box_region_allocator_core
  import gbra_pkg::*;
#(
  parameter int MaxBoxes = DefMaxBoxes
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_t                   out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [GridRegBits-1:0] cfg_data_i
);

  localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxBoxes);

  typedef enum logic [2:0] {
    SIdle, SStart, SScanRd, SScanEv, SStore, SMoveRd, SMoveWr, SDone
  } state_e;

  typedef enum logic [2:0] {
    POvl, PHit, PNx, PNy, PNz, PRel, PQry
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [CntW-1:0] idx_q, idx_d, count_q, count_d, idx_inc;
  in_t req_q, req_d;
  logic [CoordBits-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [SizeBits-1:0] best_q, best_d;
  logic found_q, found_d;
  out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [GridRegBits-1:0] grid_x_q, grid_y_q, grid_z_q;

  logic [SizeBits-1:0] eff_x, eff_y, eff_z, lim_x, lim_y, lim_z;
  logic [SizeBits-1:0] ax_end, ax_lim, ax_cur;
  logic size_zero, out_bounds, too_big;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  geom_t geom;

  gbra_table #(
    .Depth(MaxBoxes),
    .IdxW (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  gbra_geom u_geom (
    .entry_i(rdata),
    .req_i  (req_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .pz_i   (pz_q),
    .geom_o (geom)
  );

  assign eff_x = eff_grid(grid_x_q);
  assign eff_y = eff_grid(grid_y_q);
  assign eff_z = eff_grid(grid_z_q);
  assign lim_x = eff_x - req_q.extent_x;
  assign lim_y = eff_y - req_q.extent_y;
  assign lim_z = eff_z - req_q.extent_z;

  assign size_zero  = (req_q.extent_x == '0) || (req_q.extent_y == '0) ||
                      (req_q.extent_z == '0);
  // One extra bit keeps the far edge of an oversized box from wrapping.
  assign out_bounds = ((SizeBits+1)'(req_q.pos_x) + (SizeBits+1)'(req_q.extent_x) >
                       (SizeBits+1)'(eff_x)) ||
                      ((SizeBits+1)'(req_q.pos_y) + (SizeBits+1)'(req_q.extent_y) >
                       (SizeBits+1)'(eff_y)) ||
                      ((SizeBits+1)'(req_q.pos_z) + (SizeBits+1)'(req_q.extent_z) >
                       (SizeBits+1)'(eff_z));
  assign too_big    = (req_q.extent_x > eff_x) || (req_q.extent_y > eff_y) ||
                      (req_q.extent_z > eff_z);

  assign idx_inc = idx_q + CntW'(1);

  // Axis under advance during the next-candidate passes.
  always_comb begin
    case (phase_q)
      PNy: begin
        ax_end = geom.end_y;
        ax_lim = lim_y;
        ax_cur = SizeBits'(py_q);
      end
      PNz: begin
        ax_end = geom.end_z;
        ax_lim = lim_z;
        ax_cur = SizeBits'(pz_q);
      end
      default: begin
        ax_end = geom.end_x;
        ax_lim = lim_x;
        ax_cur = SizeBits'(px_q);
      end
    endcase
  end

  assign in_ready_o  = (state_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    count_d     = count_q;
    req_d       = req_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    best_d      = best_q;
    found_d     = found_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = idx_q[IdxW-1:0];
    wdata       = rdata;
    raddr       = idx_q[IdxW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = SStart;
        end
      end
      SStart: begin
        idx_d   = '0;
        state_d = SScanRd;
        px_d    = '0;
        py_d    = '0;
        pz_d    = '0;
        found_d = 1'b0;
        case (mode_e'(req_q.mode))
          ModeAlloc: begin
            px_d    = req_q.pos_x;
            py_d    = req_q.pos_y;
            pz_d    = req_q.pos_z;
            phase_d = POvl;
            if (size_zero || out_bounds) begin
              res_d   = err_out(StBounds);
              state_d = SDone;
            end
          end
          ModeFirstFit: begin
            phase_d = PHit;
            if (size_zero) begin
              res_d   = err_out(StBounds);
              state_d = SDone;
            end else if (too_big) begin
              res_d   = err_out(StNoFree);
              state_d = SDone;
            end
          end
          ModeRelease: phase_d = PRel;
          default:     phase_d = PQry;
        endcase
      end
      SScanRd: begin
        if (idx_q == count_q) begin
          // Whole table seen without an early exit.
          idx_d   = '0;
          found_d = 1'b0;
          case (phase_q)
            POvl, PHit: begin
              if (count_q == CntMax) begin
                res_d   = err_out(StFull);
                state_d = SDone;
              end else begin
                state_d = SStore;
              end
            end
            PNx: begin
              if (found_q) begin
                px_d    = best_q[CoordBits-1:0];
                phase_d = PHit;
              end else begin
                px_d    = '0;
                phase_d = PNy;
              end
            end
            PNy: begin
              if (found_q) begin
                py_d    = best_q[CoordBits-1:0];
                phase_d = PHit;
              end else begin
                py_d    = '0;
                phase_d = PNz;
              end
            end
            PNz: begin
              if (found_q) begin
                pz_d    = best_q[CoordBits-1:0];
                phase_d = PHit;
              end else begin
                res_d   = err_out(StNoFree);
                state_d = SDone;
              end
            end
            default: begin
              res_d   = err_out(StNotFound);
              state_d = SDone;
            end
          endcase
        end else begin
          state_d = SScanEv;
        end
      end
      SScanEv: begin
        idx_d   = idx_inc;
        state_d = SScanRd;
        case (phase_q)
          POvl: begin
            if (geom.hit) begin
              res_d   = err_out(StOverlap);
              state_d = SDone;
            end
          end
          PHit: begin
            if (geom.hit) begin
              idx_d   = '0;
              found_d = 1'b0;
              phase_d = PNx;
            end
          end
          PNx, PNy, PNz: begin
            if ((ax_end > ax_cur) && (ax_end <= ax_lim) &&
                (!found_q || (ax_end < best_q))) begin
              best_d  = ax_end;
              found_d = 1'b1;
            end
          end
          PRel: begin
            if (geom.match) begin
              res_d = '{status: StOk, box_x: rdata.cx, box_y: rdata.cy, box_z: rdata.cz,
                        box_size_x: rdata.sx, box_size_y: rdata.sy, box_size_z: rdata.sz,
                        box_owner: rdata.owner};
              idx_d   = idx_q;
              state_d = SMoveRd;
            end
          end
          default: begin
            if (geom.contains) begin
              res_d = '{status: StOk, box_x: rdata.cx, box_y: rdata.cy, box_z: rdata.cz,
                        box_size_x: rdata.sx, box_size_y: rdata.sy, box_size_z: rdata.sz,
                        box_owner: rdata.owner};
              state_d = SDone;
            end
          end
        endcase
      end
      SStore: begin
        we    = 1'b1;
        waddr = count_q[IdxW-1:0];
        wdata = '{cx: px_q, cy: py_q, cz: pz_q, sx: req_q.extent_x, sy: req_q.extent_y,
                  sz: req_q.extent_z, owner: req_q.owner_id};
        count_d = count_q + CntW'(1);
        res_d = '{status: StOk, box_x: px_q, box_y: py_q, box_z: pz_q,
                  box_size_x: req_q.extent_x, box_size_y: req_q.extent_y,
                  box_size_z: req_q.extent_z, box_owner: req_q.owner_id};
        state_d = SDone;
      end
      SMoveRd: begin
        // Close the gap: entry idx+1 moves down to idx.
        raddr = idx_inc[IdxW-1:0];
        if (idx_inc < count_q) begin
          state_d = SMoveWr;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = SDone;
        end
      end
      SMoveWr: begin
        we      = 1'b1;
        waddr   = idx_q[IdxW-1:0];
        wdata   = rdata;
        idx_d   = idx_inc;
        state_d = SMoveRd;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= POvl;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      grid_x_q    <= GridRegBits'(1024);
      grid_y_q    <= GridRegBits'(1024);
      grid_z_q    <= GridRegBits'(1024);
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgGridX: grid_x_q <= cfg_data_i;
          CfgGridY: grid_y_q <= cfg_data_i;
          CfgGridZ: grid_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

// File: design/gbra_table.sv
// Box table memory: one write port, one read port, registered read data.
// Depends on gbra_pkg for the entry type.
module gbra_table
  import gbra_pkg::*;
#(
  parameter int Depth = DefMaxBoxes,
  parameter int IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/gbra_geom.sv
// Compares one stored box with the probe corner, the request box and the query point.
// Depends on gbra_pkg for the entry, request and result types.
module gbra_geom
  import gbra_pkg::*;
(
  input  entry_t               entry_i,
  input  in_t                  req_i,
  input  logic [CoordBits-1:0] px_i,
  input  logic [CoordBits-1:0] py_i,
  input  logic [CoordBits-1:0] pz_i,
  output geom_t                geom_o
);

  logic [SizeBits-1:0] ex, ey, ez;
  logic [SizeBits-1:0] qx, qy, qz;
  logic                ovx, ovy, ovz;
  logic                inx, iny, inz;

  assign ex = SizeBits'(entry_i.cx) + entry_i.sx;
  assign ey = SizeBits'(entry_i.cy) + entry_i.sy;
  assign ez = SizeBits'(entry_i.cz) + entry_i.sz;

  // Far edge of the probe box.
  assign qx = SizeBits'(px_i) + req_i.extent_x;
  assign qy = SizeBits'(py_i) + req_i.extent_y;
  assign qz = SizeBits'(pz_i) + req_i.extent_z;

  assign ovx = (qx > SizeBits'(entry_i.cx)) && (SizeBits'(px_i) < ex);
  assign ovy = (qy > SizeBits'(entry_i.cy)) && (SizeBits'(py_i) < ey);
  assign ovz = (qz > SizeBits'(entry_i.cz)) && (SizeBits'(pz_i) < ez);

  assign inx = (req_i.pos_x >= entry_i.cx) && (SizeBits'(req_i.pos_x) < ex);
  assign iny = (req_i.pos_y >= entry_i.cy) && (SizeBits'(req_i.pos_y) < ey);
  assign inz = (req_i.pos_z >= entry_i.cz) && (SizeBits'(req_i.pos_z) < ez);

  always_comb begin
    geom_o.hit      = ovx && ovy && ovz;
    geom_o.contains = inx && iny && inz;
    geom_o.match    = (entry_i.cx == req_i.pos_x) && (entry_i.cy == req_i.pos_y) &&
                      (entry_i.cz == req_i.pos_z) && (entry_i.sx == req_i.extent_x) &&
                      (entry_i.sy == req_i.extent_y) && (entry_i.sz == req_i.extent_z);
    geom_o.end_x    = ex;
    geom_o.end_y    = ey;
    geom_o.end_z    = ez;
  end

endmodule
